// ===== hdl/mono_page_framebuffer_writer_defines.svh =====
`ifndef MONO_PAGE_FRAMEBUFFER_WRITER_DEFINES_SVH
`define MONO_PAGE_FRAMEBUFFER_WRITER_DEFINES_SVH

// check in the same cycle; uses clk and arst_n of the enclosing module
`define MPFW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check in the following cycle
`define MPFW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/mpfw_pkg.sv =====
package mpfw_pkg;

	localparam int DISPLAY_WIDTH  = 128;
	localparam int DISPLAY_HEIGHT = 64;
	localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
	localparam int STORE_BYTES    = PAGE_COUNT * DISPLAY_WIDTH;
	localparam int ADDR_W         = $clog2(STORE_BYTES);

	localparam int GLYPH_COUNT = 37;
	localparam int GLYPH_W     = 6;
	localparam int GLYPH_COLS  = 8;
	localparam int GCOL_W      = $clog2(GLYPH_COLS);
	localparam int GCNT_W      = GCOL_W + 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 8;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_DISPLAY_READY = '0;

	localparam logic [1:0] OP_PIXEL = 2'd0;
	localparam logic [1:0] OP_GLYPH = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [2:0] CMD_NOP   = 3'd0;
	localparam logic [2:0] CMD_PIXEL = 3'd1;
	localparam logic [2:0] CMD_GLYPH = 3'd2;
	localparam logic [2:0] CMD_CLEAR = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	typedef logic [0:GLYPH_COLS-1][7:0] glyph_row_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic               ignored;
		logic [ADDR_W-1:0]  addr;
		logic [2:0]         bit_sel;
		logic               pixel_on;
		logic [GLYPH_W-1:0] glyph;
		logic [GCNT_W-1:0]  cols;
	} cmd_t;

	typedef struct packed {
		logic init_busy;
	} back_status_t;

	function automatic logic [GLYPH_W-1:0] glyph_of(input logic [7:0] ch);
		logic [GLYPH_W-1:0] g;
		g = '0;
		if (ch >= 8'h41 && ch <= 8'h5a)
			g = GLYPH_W'(ch - 8'd64);
		else if (ch >= 8'h61 && ch <= 8'h7a)
			g = GLYPH_W'(ch - 8'd96);
		else if (ch >= 8'h30 && ch <= 8'h39)
			g = GLYPH_W'(ch - 8'd21);
		return g;
	endfunction

	function automatic glyph_row_t glyph_bits(input logic [GLYPH_W-1:0] g);
		glyph_row_t r;
		case (g)
			6'd1:  r = {8'h78, 8'h14, 8'h12, 8'h11, 8'h12, 8'h14, 8'h78, 8'h00};
			6'd2:  r = {8'h7f, 8'h49, 8'h49, 8'h49, 8'h49, 8'h49, 8'h7f, 8'h00};
			6'd3:  r = {8'h7e, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h00};
			6'd4:  r = {8'h7f, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h7e, 8'h00};
			6'd5:  r = {8'h7f, 8'h49, 8'h49, 8'h49, 8'h49, 8'h49, 8'h49, 8'h00};
			6'd6:  r = {8'h7f, 8'h09, 8'h09, 8'h09, 8'h09, 8'h01, 8'h01, 8'h00};
			6'd7:  r = {8'h7f, 8'h41, 8'h41, 8'h41, 8'h51, 8'h51, 8'h73, 8'h00};
			6'd8:  r = {8'h7f, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h7f, 8'h00};
			6'd9:  r = {8'h00, 8'h00, 8'h00, 8'h7f, 8'h00, 8'h00, 8'h00, 8'h00};
			6'd10: r = {8'h21, 8'h41, 8'h41, 8'h3f, 8'h01, 8'h01, 8'h01, 8'h00};
			6'd11: r = {8'h00, 8'h7f, 8'h08, 8'h08, 8'h14, 8'h22, 8'h41, 8'h00};
			6'd12: r = {8'h7f, 8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 8'h00};
			6'd13: r = {8'h7f, 8'h02, 8'h04, 8'h08, 8'h04, 8'h02, 8'h7f, 8'h00};
			6'd14: r = {8'h7f, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h7f, 8'h00};
			6'd15: r = {8'h3e, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h3e, 8'h00};
			6'd16: r = {8'h7f, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0e, 8'h00};
			6'd17: r = {8'h3e, 8'h41, 8'h41, 8'h49, 8'h51, 8'h61, 8'h7e, 8'h00};
			6'd18: r = {8'h7f, 8'h11, 8'h11, 8'h11, 8'h31, 8'h51, 8'h0e, 8'h00};
			6'd19: r = {8'h46, 8'h49, 8'h49, 8'h49, 8'h49, 8'h30, 8'h00, 8'h00};
			6'd20: r = {8'h01, 8'h01, 8'h01, 8'h7f, 8'h01, 8'h01, 8'h01, 8'h00};
			6'd21: r = {8'h3f, 8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 8'h3f, 8'h00};
			6'd22: r = {8'h0f, 8'h10, 8'h20, 8'h40, 8'h20, 8'h10, 8'h0f, 8'h00};
			6'd23: r = {8'h7f, 8'h20, 8'h10, 8'h08, 8'h10, 8'h20, 8'h7f, 8'h00};
			6'd24: r = {8'h00, 8'h41, 8'h22, 8'h14, 8'h14, 8'h22, 8'h41, 8'h00};
			6'd25: r = {8'h01, 8'h02, 8'h04, 8'h78, 8'h04, 8'h02, 8'h01, 8'h00};
			6'd26: r = {8'h41, 8'h61, 8'h59, 8'h45, 8'h43, 8'h41, 8'h00, 8'h00};
			6'd27: r = {8'h3e, 8'h41, 8'h41, 8'h49, 8'h41, 8'h41, 8'h3e, 8'h00};
			6'd28: r = {8'h00, 8'h00, 8'h42, 8'h7f, 8'h40, 8'h00, 8'h00, 8'h00};
			6'd29: r = {8'h30, 8'h49, 8'h49, 8'h49, 8'h49, 8'h46, 8'h00, 8'h00};
			6'd30: r = {8'h49, 8'h49, 8'h49, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00};
			6'd31: r = {8'h3f, 8'h20, 8'h20, 8'h78, 8'h20, 8'h20, 8'h00, 8'h00};
			6'd32: r = {8'h4f, 8'h49, 8'h49, 8'h49, 8'h49, 8'h30, 8'h00, 8'h00};
			6'd33: r = {8'h3f, 8'h48, 8'h48, 8'h48, 8'h48, 8'h48, 8'h30, 8'h00};
			6'd34: r = {8'h01, 8'h01, 8'h01, 8'h61, 8'h31, 8'h0d, 8'h03, 8'h00};
			6'd35: r = {8'h36, 8'h49, 8'h49, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00};
			6'd36: r = {8'h06, 8'h09, 8'h09, 8'h09, 8'h09, 8'h09, 8'h7f, 8'h00};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/mpfw_ram.sv =====
module mpfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/mpfw_front.sv =====
module mpfw_front
	import mpfw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 display_ready,
	input  back_status_t         status,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // x_pos[7:0], y_pos[15:8], pixel_on[16], char_code[24:17]
	input  logic [1:0]           s_tuser,  // op[1:0]
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output cmd_t                 cmd
);

	logic [7:0] x_pos;
	logic [7:0] y_pos;
	logic       pixel_on;
	logic [7:0] char_code;
	logic [4:0] page;
	logic       x_in;
	logic       y_in;
	logic       page_in;
	logic [15:0] addr_full;
	logic [8:0] remaining;
	cmd_t       cls;

	cmd_t              q_mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign x_pos     = s_tdata[7:0];
	assign y_pos     = s_tdata[15:8];
	assign pixel_on  = s_tdata[16];
	assign char_code = s_tdata[24:17];
	assign page      = y_pos[7:3];

	assign x_in      = {1'b0, x_pos} < 9'(DISPLAY_WIDTH);
	assign y_in      = {1'b0, y_pos} < 9'(DISPLAY_HEIGHT);
	assign page_in   = {1'b0, page} < 6'(PAGE_COUNT);
	assign addr_full = 16'(page) * 16'(DISPLAY_WIDTH) + 16'(x_pos);
	assign remaining = 9'(DISPLAY_WIDTH) - {1'b0, x_pos};

	// classify
	always_comb begin
		cls.kind     = CMD_NOP;
		cls.ignored  = 1'b0;
		cls.addr     = ADDR_W'(addr_full);
		cls.bit_sel  = y_pos[2:0];
		cls.pixel_on = pixel_on;
		cls.glyph    = glyph_of(char_code);
		cls.cols     = (remaining > 9'(GLYPH_COLS)) ? GCNT_W'(GLYPH_COLS) : GCNT_W'(remaining);
		if (s_tuser == OP_READ) begin
			if (x_in && page_in)
				cls.kind = CMD_READ;
		end else if (!display_ready) begin
			cls.ignored = 1'b1;
		end else begin
			case (s_tuser)
				OP_PIXEL: if (x_in && y_in) cls.kind = CMD_PIXEL;
				OP_GLYPH: if (x_in && page_in) cls.kind = CMD_GLYPH;
				OP_CLEAR: cls.kind = CMD_CLEAR;
				default:  cls.kind = CMD_NOP;
			endcase
		end
	end

	assign s_tready  = !status.init_busy && (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = count_q != '0;
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= cls;
	end

endmodule

// ===== hdl/mpfw_back.sv =====
`include "mono_page_framebuffer_writer_defines.svh"

module mpfw_back
	import mpfw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	output back_status_t         status,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  cmd_t                 cmd,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // read_data[7:0]
	output logic                 m_tuser   // ignored
);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RMW   = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_GLYPH = 3'd4;
	localparam logic [2:0] ST_CLEAR = 3'd5;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [GCOL_W-1:0] col_q;
	cmd_t              cmd_q;
	logic              out_valid_q;
	logic [7:0]        out_data_q;
	logic              out_ign_q;

	logic              pop;
	logic              sweep_last;
	logic              glyph_last;
	glyph_row_t        grow;
	logic [7:0]        mask;
	logic              res_load;
	logic [7:0]        res_data;
	logic              res_ign;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;

	assign status.init_busy = state_q == ST_INIT;
	assign cmd_ready  = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign pop        = cmd_valid && cmd_ready;
	assign sweep_last = cnt_q == LAST_ADDR;
	assign glyph_last = {1'b0, col_q} == (cmd_q.cols - GCNT_W'(1));
	assign grow       = glyph_bits(cmd_q.glyph);
	assign mask       = 8'b1 << cmd_q.bit_sel;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		res_load  = 1'b0;
		res_data  = '0;
		res_ign   = 1'b0;
		case (state_q)
			ST_INIT: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				if (pop && cmd.kind == CMD_NOP) begin
					res_load = 1'b1;
					res_ign  = cmd.ignored;
				end
			end
			ST_RMW: begin
				ram_we    = 1'b1;
				ram_waddr = cmd_q.addr;
				ram_wdata = cmd_q.pixel_on ? (ram_rdata | mask) : (ram_rdata & ~mask);
				res_load  = 1'b1;
			end
			ST_READ: begin
				res_load = 1'b1;
				res_data = ram_rdata;
			end
			ST_GLYPH: begin
				ram_we    = 1'b1;
				ram_waddr = cmd_q.addr + ADDR_W'(col_q);
				ram_wdata = grow[col_q];
				res_load  = glyph_last;
			end
			ST_CLEAR: begin
				ram_we   = 1'b1;
				res_load = sweep_last;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					if (sweep_last) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (pop) begin
						col_q <= '0;
						cnt_q <= '0;
						case (cmd.kind)
							CMD_PIXEL: state_q <= ST_RMW;
							CMD_READ:  state_q <= ST_READ;
							CMD_GLYPH: state_q <= ST_GLYPH;
							CMD_CLEAR: state_q <= ST_CLEAR;
							default:   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_GLYPH: begin
					col_q <= col_q + GCOL_W'(1);
					if (glyph_last)
						state_q <= ST_IDLE;
				end
				ST_RMW, ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= cmd;
		if (res_load) begin
			out_data_q <= res_data;
			out_ign_q  <= res_ign;
		end
	end

	mpfw_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (pop),
		.raddr (cmd.addr),
		.rdata (ram_rdata)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_ign_q;

	`MPFW_ASSERT_NOW(a_init_silent, state_q == ST_INIT, !out_valid_q,
		"result during reset sweep")
	`MPFW_ASSERT_NOW(a_glyph_cols, state_q == ST_GLYPH, GCNT_W'(col_q) < cmd_q.cols,
		"glyph column past clip")
	`MPFW_ASSERT_NEXT(a_nop_result, pop && cmd.kind == CMD_NOP, out_valid_q && state_q == ST_IDLE,
		"dropped item gave no result")
	`MPFW_ASSERT_NEXT(a_work_leaves_idle, pop && cmd.kind != CMD_NOP, state_q != ST_IDLE,
		"command not started")
	`MPFW_ASSERT_NOW(a_result_slot_free, res_load && state_q != ST_IDLE, !out_valid_q || m_tready,
		"result overwrites pending item")

endmodule

// ===== hdl/mono_page_framebuffer_writer.sv =====
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: x_pos, y_pos, pixel_on, char_code; tuser: op
// m_*       out  m_tvalid/m_tready  tdata: read_data; tuser: ignored
// apb       in   psel/penable       display_ready at address 0
//
// After reset the store is zeroed by a sweep over all 1024 bytes (STORE_BYTES); s_tready stays low.
// A dropped or clipped item is answered straight from idle; a pixel does a read-modify-write and a read
// a single store read; a glyph writes up to 8 columns, clear sweeps the whole store; one memory write per cycle.
// A two-item queue separates intake from the store sequencer; a full output register
// holds the sequencer, a full queue holds s_tready low.
module mono_page_framebuffer_writer
	import mpfw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // x_pos[7:0], y_pos[15:8], pixel_on[16], char_code[24:17]
	input  logic [1:0]           s_tuser,  // op[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // read_data[7:0]
	output logic                 m_tuser,  // ignored
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	logic         display_ready_q;
	back_status_t status;
	logic         cmd_valid;
	logic         cmd_ready;
	cmd_t         cmd;

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == REG_DISPLAY_READY) ? PDATA_W'(display_ready_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_ready_q <= 1'b0;
		end else if (psel && penable && pwrite && pready
				&& paddr[PADDR_W-1:2] == REG_DISPLAY_READY) begin
			display_ready_q <= pwdata[0];
		end
	end

	mpfw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.display_ready (display_ready_q),
		.status        (status),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd)
	);

	mpfw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.status    (status),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
